>>> design/hdsw_pkg.sv
// ----------------------------------------------------------------------------
// hdsw_pkg
// Shared types and constants for the half-duplex single-wire UART.
// ----------------------------------------------------------------------------
package hdsw_pkg;

   // Tick counter width default
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Configuration port
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int PERIOD_WIDTH   = 16;
   localparam logic CSR_IDX_BIT_PERIOD = 1'b0;   // paddr[2] of the bit period register
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd434;
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_MIN   = 16'd4;

   // Stream widths
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 16;

   // Bit sequencing
   localparam logic [3:0] BIT_START     = 4'd0;   // start bit / lead-in
   localparam logic [3:0] BIT_LAST_DATA = 4'd8;
   localparam logic [3:0] BIT_RX_STOP   = 4'd9;   // rx: waiting for mid stop bit
   localparam logic [3:0] BIT_TX_STOP   = 4'd10;  // tx: stop bit on the line

   typedef enum logic [2:0] {
      MODE_LISTEN = 3'b001,
      MODE_RECV   = 3'b010,
      MODE_SEND   = 3'b100
   } hdsw_mode_type;

   // Link state, excluding the tick counter whose width is a parameter
   typedef struct packed {
      hdsw_mode_type mode;
      logic [3:0]    bit_index;
      logic [7:0]    shift_reg;
      logic          prev_line;
      logic          drive_level;
   } hdsw_state_type;

   // Result transaction, pin_drive in bit 0
   typedef struct packed {
      logic       sending;
      logic       receiving;
      logic [7:0] recv_byte;
      logic       recv_valid;
      logic       send_taken;
      logic       pin_out;
      logic       pin_drive;
   } hdsw_result_type;

   localparam int RESULT_WIDTH = $bits(hdsw_result_type);

endpackage

>>> design/hdsw_csr.sv
// ----------------------------------------------------------------------------
// hdsw_csr
// APB-style register block holding the bit period.
// ----------------------------------------------------------------------------
module hdsw_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [hdsw_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [hdsw_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [hdsw_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                    csr_pready,
   output logic [hdsw_pkg::PERIOD_WIDTH-1:0]       bit_period
);

   logic [hdsw_pkg::PERIOD_WIDTH-1:0] period_ff;
   logic [hdsw_pkg::PERIOD_WIDTH-1:0] period_in;
   logic                              hit;
   logic                              wr_en;

   assign csr_pready = 1'b1;
   assign hit        = (csr_paddr[2] == hdsw_pkg::CSR_IDX_BIT_PERIOD);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready & hit;
   assign period_in  = wr_en ? csr_pwdata[hdsw_pkg::PERIOD_WIDTH-1:0] : period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= hdsw_pkg::PERIOD_RESET;
      end else begin
         period_ff <= period_in;
      end
   end

   assign csr_prdata = hit ? hdsw_pkg::CSR_DATA_WIDTH'(period_ff) : '0;
   assign bit_period = period_ff;

endmodule

>>> design/hdsw_step.sv
// ----------------------------------------------------------------------------
// hdsw_step
// Next-state and result logic for one clock tick of the link.
// ----------------------------------------------------------------------------
module hdsw_step #(
   parameter int COUNT_WIDTH = hdsw_pkg::COUNT_WIDTH_DEFAULT
) (
   input  hdsw_pkg::hdsw_state_type         st,
   input  logic [COUNT_WIDTH-1:0]           tick,
   input  logic [hdsw_pkg::PERIOD_WIDTH-1:0] bit_period,
   input  logic                             line_level,
   input  logic                             send_valid,
   input  logic [7:0]                       send_byte,
   output hdsw_pkg::hdsw_state_type         st_next,
   output logic [COUNT_WIDTH-1:0]           tick_next,
   output hdsw_pkg::hdsw_result_type        res
);

   localparam int CMP_WIDTH = (COUNT_WIDTH > hdsw_pkg::PERIOD_WIDTH) ?
                              COUNT_WIDTH : hdsw_pkg::PERIOD_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   logic [CMP_WIDTH-1:0]   period_ext;
   logic [COUNT_WIDTH-1:0] period;
   logic [COUNT_WIDTH-1:0] target_rx;
   logic [COUNT_WIDTH-1:0] tick_inc;
   logic [7:0]             rx_shift;

   // Clamp period to [4, counter max]
   always_comb begin
      period_ext = CMP_WIDTH'(bit_period);
      if (bit_period < hdsw_pkg::PERIOD_MIN) begin
         period_ext = CMP_WIDTH'(hdsw_pkg::PERIOD_MIN);
      end else if (period_ext > CMP_WIDTH'(COUNT_MAX)) begin
         period_ext = CMP_WIDTH'(COUNT_MAX);
      end
   end

   assign period    = period_ext[COUNT_WIDTH-1:0];
   assign target_rx = (st.bit_index == hdsw_pkg::BIT_START) ? (period >> 1) : period;
   assign tick_inc  = tick + COUNT_WIDTH'(1);
   assign rx_shift  = {line_level, st.shift_reg[7:1]};

   always_comb begin
      st_next     = st;
      tick_next   = tick;
      res         = '0;
      res.pin_out = 1'b1;
      case (st.mode)
         hdsw_pkg::MODE_RECV: begin
            res.receiving = 1'b1;
            tick_next     = tick_inc;
            if (tick_inc >= target_rx) begin
               tick_next = '0;
               if (st.bit_index == hdsw_pkg::BIT_START) begin
                  st_next.shift_reg = '0;
                  st_next.bit_index = st.bit_index + 4'd1;
               end else if (st.bit_index < hdsw_pkg::BIT_RX_STOP) begin
                  st_next.shift_reg = rx_shift;
                  st_next.bit_index = st.bit_index + 4'd1;
                  if (st.bit_index == hdsw_pkg::BIT_LAST_DATA) begin
                     res.recv_valid = 1'b1;
                     res.recv_byte  = rx_shift;
                  end
               end else begin
                  st_next.mode      = hdsw_pkg::MODE_LISTEN;
                  st_next.bit_index = hdsw_pkg::BIT_START;
               end
            end
         end
         hdsw_pkg::MODE_SEND: begin
            res.sending   = 1'b1;
            res.pin_drive = 1'b1;
            res.pin_out   = st.drive_level;
            tick_next     = tick_inc;
            if (tick_inc >= period) begin
               tick_next = '0;
               if (st.bit_index == hdsw_pkg::BIT_START ||
                   st.bit_index >= hdsw_pkg::BIT_TX_STOP) begin
                  if (send_valid) begin
                     res.send_taken      = 1'b1;
                     st_next.shift_reg   = send_byte;
                     st_next.bit_index   = 4'd1;
                     st_next.drive_level = 1'b0;
                  end else begin
                     st_next.mode        = hdsw_pkg::MODE_LISTEN;
                     st_next.bit_index   = hdsw_pkg::BIT_START;
                     st_next.drive_level = 1'b1;
                  end
               end else if (st.bit_index <= hdsw_pkg::BIT_LAST_DATA) begin
                  st_next.drive_level = st.shift_reg[0];
                  st_next.shift_reg   = {1'b0, st.shift_reg[7:1]};
                  st_next.bit_index   = st.bit_index + 4'd1;
               end else begin
                  st_next.drive_level = 1'b1;
                  st_next.bit_index   = hdsw_pkg::BIT_TX_STOP;
               end
            end
         end
         default: begin
            // listening; unknown codes fall back here
            st_next.mode = hdsw_pkg::MODE_LISTEN;
            if (st.prev_line && !line_level) begin
               st_next.mode      = hdsw_pkg::MODE_RECV;
               tick_next         = '0;
               st_next.bit_index = hdsw_pkg::BIT_START;
               st_next.shift_reg = '0;
            end else if (send_valid) begin
               st_next.mode        = hdsw_pkg::MODE_SEND;
               tick_next           = '0;
               st_next.bit_index   = hdsw_pkg::BIT_START;
               st_next.drive_level = 1'b1;
            end
         end
      endcase
      st_next.prev_line = line_level;
   end

endmodule

>>> design/half_duplex_single_wire_uart.sv
// ----------------------------------------------------------------------------
// half_duplex_single_wire_uart
// Single-pin half-duplex 8N1 UART, advanced by one tick per transaction.
// ----------------------------------------------------------------------------
//  channel | ports        | width | carries
//  --------+--------------+-------+-------------------------------------------
//  req     | req_t*       | 16    | one timer tick: pin level, byte to send
//  rsp     | rsp_t*       | 16    | pin drive, rx byte, status for that tick
//  csr     | csr_p*       | 32    | bit period register at address 0
//
//  Each req transaction is processed combinationally; its rsp transaction
//  is presented from the output register in the following cycle.
//  Throughput is one transaction per cycle, limited only by rsp_tready.
//  req_tready is low only while a finished result waits in the output
//  register and rsp_tready is low; link state then holds.
//  Synchronous active-high reset: link listening, line assumed idle high,
//  bit period 434 ticks. No clearing pass.
// ----------------------------------------------------------------------------
module half_duplex_single_wire_uart #(
   parameter int COUNT_WIDTH = hdsw_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: [0] line_level, [1] send_valid, [9:2] send_byte, [15:10] zero
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [hdsw_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // rsp_tdata: [0] pin_drive, [1] pin_out, [2] send_taken, [3] recv_valid,
   //            [11:4] recv_byte, [12] receiving, [13] sending, [15:14] zero
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [hdsw_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [hdsw_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [hdsw_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [hdsw_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   logic [hdsw_pkg::PERIOD_WIDTH-1:0] bit_period;

   // Link state, advanced on every accepted transaction
   hdsw_pkg::hdsw_state_type  state_ff;
   hdsw_pkg::hdsw_state_type  state_in;
   logic [COUNT_WIDTH-1:0]    tick_ff;
   logic [COUNT_WIDTH-1:0]    tick_in;
   hdsw_pkg::hdsw_result_type result;

   // Output register
   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic [hdsw_pkg::RESULT_WIDTH-1:0]   out_data_ff;
   logic [hdsw_pkg::RESULT_WIDTH-1:0]   out_data_in;

   logic req_fire;

   hdsw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .bit_period  (bit_period)
   );

   hdsw_step #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_step (
      .st         (state_ff),
      .tick       (tick_ff),
      .bit_period (bit_period),
      .line_level (req_tdata[0]),
      .send_valid (req_tdata[1]),
      .send_byte  (req_tdata[9:2]),
      .st_next    (state_in),
      .tick_next  (tick_in),
      .res        (result)
   );

   // Accept while the output slot is empty or being drained
   assign req_tready = !out_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode        <= hdsw_pkg::MODE_LISTEN;
         state_ff.bit_index   <= hdsw_pkg::BIT_START;
         state_ff.shift_reg   <= '0;
         state_ff.prev_line   <= 1'b1;
         state_ff.drive_level <= 1'b1;
         tick_ff              <= '0;
      end else if (req_fire) begin
         state_ff <= state_in;
         tick_ff  <= tick_in;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (req_fire) begin
         out_valid_in = 1'b1;
         out_data_in  = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = hdsw_pkg::RSP_DATA_WIDTH'(out_data_ff);

endmodule

>>> design/hdsw_checker.sv
// ----------------------------------------------------------------------------
// hdsw_checker
// Port-level checks on the UART result stream, bound to the top level.
// ----------------------------------------------------------------------------
module hdsw_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [hdsw_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   // Draining output frees the input side in the same cycle
   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req_tready low while rsp side ready");

   // Never receiving and sending at once
   a_mode_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[12] && rsp_tdata[13]))
      else $error("receiving and sending both set");

   // Pin driven exactly while sending; released pin reads high
   a_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == rsp_tdata[13]) && (rsp_tdata[0] || rsp_tdata[1]))
      else $error("pin drive inconsistent with sending");

   // Byte taken only when sending, delivered only when receiving
   a_events: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[2] || rsp_tdata[13]) && (!rsp_tdata[3] || rsp_tdata[12]))
      else $error("send_taken or recv_valid outside its mode");

endmodule

bind half_duplex_single_wire_uart hdsw_checker u_hdsw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
